// ----- rtl/jch_pkg.sv -----
`timescale 1ns / 1ps

package jch_pkg;

  // Multiplier of the 64-bit linear congruential key walk.
  localparam logic [63:0] JchMult = 64'd2862933555777941757;

  // The jump quotient is only needed when it fits in a bucket index.
  localparam int unsigned BucketW = 16;
  localparam int unsigned DivSteps = BucketW;
  localparam int unsigned DivCntW = $clog2(DivSteps);

  typedef struct packed {
    logic load;       // take a new key
    logic mul0;       // low x low partial product
    logic mul1;       // low x high partial product
    logic mul2;       // high x low partial product
    logic mul3;       // assemble the new key state
    logic chk;        // form divisor, test for a large jump
    logic div_step;   // one quotient bit
    logic take_jump;  // candidate bucket becomes the jump
    logic emit;       // move the result into the output register
  } jch_cmd_t;

  typedef struct packed {
    logic n_zero;     // no buckets configured
    logic big;        // jump is at least 2^16, so the walk ends
    logic jump_lt_n;  // jump still inside the bucket range
    logic out_free;   // output register can take a word
  } jch_status_t;

endpackage

// ----- rtl/jch_datapath.sv -----
`timescale 1ns / 1ps

module jch_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jch_pkg::jch_cmd_t   cmd_i,
  output jch_pkg::jch_status_t status_o,
  input  logic                cfg_valid_i,
  input  logic [15:0]         cfg_num_buckets_i,
  input  logic [63:0]         key_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         bucket_o,
  output logic                valid_res_o
);

  logic [15:0] n_q;
  logic [63:0] k_q, k_d;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [15:0] b_q;
  logic        res_valid_q;
  logic [31:0] d_q, d_d;
  logic [30:0] r_q;
  logic [15:0] q_q;
  logic        out_valid_q;
  logic [15:0] bucket_q;
  logic        valid_res_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [16:0] bp1;
  logic [31:0] num_hi;
  logic [31:0] r_sh;
  logic        r_ge;

  // One shared 32x32 multiplier; the key update needs three products mod 2^64.
  assign mul_a = (cmd_i.mul0 || cmd_i.mul1) ? k_q[31:0] : k_q[63:32];
  assign mul_b = cmd_i.mul1 ? jch_pkg::JchMult[63:32] : jch_pkg::JchMult[31:0];
  assign mul_p = mul_a * mul_b;

  assign k_d = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};

  // The numerator is (b+1)*2^31, whose low 31 bits are zero. The quotient
  // reaches 2^16 exactly when (b+1)*2^15 is at least the divisor.
  assign bp1    = {1'b0, b_q} + 17'd1;
  assign num_hi = {bp1[16:0], 15'd0};
  assign d_d    = {1'b0, k_q[63:33]} + 32'd1;

  assign r_sh = {r_q, 1'b0};
  assign r_ge = (r_sh >= d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= 16'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        n_q <= cfg_num_buckets_i;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q         <= key_i;
      b_q         <= '0;
      res_valid_q <= (n_q != '0);
    end
    if (cmd_i.mul0 || cmd_i.mul1 || cmd_i.mul2) begin
      prod_q <= mul_p;
    end
    if (cmd_i.mul1) begin
      // The low product is at most 2^64 - 2^33 + 1, so the +1 cannot wrap.
      acc_q <= prod_q + 64'd1;
    end
    if (cmd_i.mul2) begin
      acc_q <= k_d;
    end
    if (cmd_i.mul3) begin
      k_q <= k_d;
    end
    if (cmd_i.chk) begin
      d_q <= d_d;
      r_q <= num_hi[30:0];
      q_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (r_ge) begin
        r_q <= 31'(r_sh - d_q);
      end else begin
        r_q <= r_sh[30:0];
      end
      q_q <= {q_q[14:0], r_ge};
    end
    if (cmd_i.take_jump) begin
      b_q <= q_q;
    end
    if (cmd_i.emit) begin
      bucket_q    <= b_q;
      valid_res_q <= res_valid_q;
    end
  end

  assign status_o.n_zero    = (n_q == '0);
  assign status_o.big       = (num_hi >= d_d);
  assign status_o.jump_lt_n = (q_q < n_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign bucket_o    = bucket_q;
  assign valid_res_o = valid_res_q;

endmodule

// ----- rtl/jch_ctrl.sv -----
`timescale 1ns / 1ps

module jch_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  jch_pkg::jch_status_t status_i,
  output jch_pkg::jch_cmd_t    cmd_o
);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SMul0 = 4'd1;
  localparam logic [3:0] SMul1 = 4'd2;
  localparam logic [3:0] SMul2 = 4'd3;
  localparam logic [3:0] SMul3 = 4'd4;
  localparam logic [3:0] SChk  = 4'd5;
  localparam logic [3:0] SDiv  = 4'd6;
  localparam logic [3:0] SNext = 4'd7;
  localparam logic [3:0] SDone = 4'd8;

  localparam logic [jch_pkg::DivCntW-1:0] DivLast = jch_pkg::DivCntW'(jch_pkg::DivSteps - 1);

  logic [3:0]                   state_q, state_d;
  logic [jch_pkg::DivCntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.n_zero ? SDone : SMul0;
        end
      end
      SMul0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = SMul1;
      end
      SMul1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = SMul2;
      end
      SMul2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = SMul3;
      end
      SMul3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = SChk;
      end
      SChk: begin
        cmd_o.chk = 1'b1;
        cnt_d     = '0;
        state_d   = status_i.big ? SDone : SDiv;
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = SNext;
        end
      end
      SNext: begin
        if (status_i.jump_lt_n) begin
          cmd_o.take_jump = 1'b1;
          state_d         = SMul0;
        end else begin
          state_d = SDone;
        end
      end
      SDone: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/jump_consistent_hash_core.sv -----
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    key_i (64)
// result    out_valid_o / out_ready_i  bucket_o (16), valid_res_o (1)
// config    cfg_valid_i / cfg_ready_o  cfg_num_buckets_i (16)
//
// Each round of the walk runs the key update on the shared 32x32 multiplier
// (three partial products, then assembly), a divisor check, the bit-serial
// 16-bit quotient and a compare. The last round stops after its check only
// when the jump reaches 2^16. A key takes about ln(n)+1 rounds; with zero
// buckets it skips the walk. One key is in flight; a finished word waits in the
// output register while the next key is taken. Reset sets num_buckets to 1.

module jump_consistent_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_num_buckets_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] bucket_o,
  output logic        valid_res_o
);

  jch_pkg::jch_cmd_t    cmd;
  jch_pkg::jch_status_t status;

  assign cfg_ready_o = 1'b1;

  jch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  jch_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_num_buckets_i (cfg_num_buckets_i),
    .key_i             (key_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .bucket_o          (bucket_o),
    .valid_res_o       (valid_res_o)
  );

endmodule

// ----- rtl/jch_checker.sv -----
`timescale 1ns / 1ps

module jch_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] bucket_o,
  input logic        valid_res_o
);

  // A held result word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bucket_o) && $stable(valid_res_o))
    else $error("result word changed while stalled");

  // A word with no bucket chosen reports bucket zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> bucket_o == 16'd0)
    else $error("invalid result carries a nonzero bucket");

  // A key is never accepted back to back: taking a key moves the controller out of idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a key was accepted");

  // A new result word only appears after a key has been accepted earlier.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while the core was idle");

endmodule

bind jump_consistent_hash_core jch_checker u_jch_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .bucket_o    (bucket_o),
  .valid_res_o (valid_res_o)
);
